// ===== rtl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB565 to BMP24 formatter package
// Shared types and constants for the BMP byte stream formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

   localparam int CFG_W       = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int PIXEL_W     = 16;
   localparam int FIELD_W     = 32;
   localparam int IDX_W       = 6;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   localparam int HDR_BYTES = 54;

   localparam logic [7:0]         MAGIC_B        = 8'h42;
   localparam logic [7:0]         MAGIC_M        = 8'h4D;
   localparam logic [FIELD_W-1:0] DATA_OFFSET    = 32'd54;
   localparam logic [FIELD_W-1:0] INFO_BYTES     = 32'd40;
   localparam logic [15:0]        PLANES         = 16'd1;
   localparam logic [15:0]        BITS_PER_PIXEL = 16'd24;
   localparam logic [FIELD_W-1:0] PELS_PER_METRE = 32'd2835;

   localparam logic [IDX_W-1:0] IDX_HDR_FIRST = 6'd0;
   localparam logic [IDX_W-1:0] IDX_PIX_B     = 6'd54;
   localparam logic [IDX_W-1:0] IDX_PIX_G     = 6'd55;
   localparam logic [IDX_W-1:0] IDX_PIX_R     = 6'd56;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               header;
      logic               frame_done;
      logic [1:0]         pad_count;
   } cmd_type;

   typedef struct packed {
      logic [FIELD_W-1:0] file_size;
      logic [FIELD_W-1:0] data_size;
      logic [FIELD_W-1:0] width;
      logic [FIELD_W-1:0] height;
   } geom_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       run_last;
      logic       frame_end;
   } out_type;

endpackage

`default_nettype wire

// ===== rtl/rbf_fifo.sv =====
// ----------------------------------------------------------------------------
// Small FIFO
// Flip-flop queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rbf_csr.sv =====
// ----------------------------------------------------------------------------
// Formatter configuration registers
// Holds image width and height, clamps them and derives the header sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_csr #(
   parameter int MAX_DIMENSION = 4096,
   parameter int DIM_W         = 13
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rbf_pkg::CFG_W-1:0]       csr_data,
   output logic      [DIM_W-1:0]                width_eff,
   output logic      [DIM_W-1:0]                height_eff,
   output rbf_pkg::geom_type                    geom
);

   localparam int ROW_W  = DIM_W + 2;
   localparam int SIZE_W = ROW_W + DIM_W;

   logic [rbf_pkg::CFG_W-1:0]   width_ff, width_in;
   logic [rbf_pkg::CFG_W-1:0]   height_ff, height_in;
   logic [ROW_W-1:0]            row_bytes_ff, row_bytes_in;
   logic [DIM_W-1:0]            height_d_ff;
   logic [SIZE_W-1:0]           data_size_ff, data_size_in;
   logic [rbf_pkg::FIELD_W-1:0] file_size_ff, file_size_in;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [rbf_pkg::CFG_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide == 32'd0) begin
         return DIM_W'(1);
      end else if (wide > 32'(MAX_DIMENSION)) begin
         return DIM_W'(MAX_DIMENSION);
      end
      return DIM_W'(v);
   endfunction

   assign csr_ready  = 1'b1;
   assign width_eff  = clamp_dim(width_ff);
   assign height_eff = clamp_dim(height_ff);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rbf_pkg::REG_IMAGE_WIDTH:  width_in  = csr_data;
            rbf_pkg::REG_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   assign row_bytes_in  = (ROW_W'(width_eff) << 1) + ROW_W'(width_eff)
                          + ROW_W'(width_eff[1:0]);
   assign data_size_in  = SIZE_W'(row_bytes_ff) * SIZE_W'(height_d_ff);
   assign file_size_in  = rbf_pkg::FIELD_W'(data_size_ff) + rbf_pkg::DATA_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rbf_pkg::WIDTH_RESET;
         height_ff <= rbf_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      row_bytes_ff  <= row_bytes_in;
      height_d_ff   <= height_eff;
      data_size_ff  <= data_size_in;
      file_size_ff  <= file_size_in;
   end

   assign geom.file_size = file_size_ff;
   assign geom.data_size = rbf_pkg::FIELD_W'(data_size_ff);
   assign geom.width     = rbf_pkg::FIELD_W'(width_eff);
   assign geom.height    = rbf_pkg::FIELD_W'(height_eff);

endmodule

`default_nettype wire

// ===== rtl/rbf_front.sv =====
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts pixels, tracks row and column, and classifies each pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_front #(
   parameter int MAX_DIMENSION = 4096,
   parameter int DIM_W         = 13
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [rbf_pkg::PIXEL_W-1:0] req_pixel_rgb565,
   input  wire logic [DIM_W-1:0]            width_eff,
   input  wire logic [DIM_W-1:0]            height_eff,
   output logic                             cmd_push,
   input  wire logic                        cmd_full,
   output rbf_pkg::cmd_type                 cmd
);

   localparam int CNT_W = $clog2(MAX_DIMENSION);

   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [DIM_W:0]   column_next;
   logic [DIM_W:0]   row_next;
   logic             row_end;
   logic             last_row;

   assign req_full    = cmd_full;
   assign cmd_push    = req_push && !cmd_full;
   assign column_next = (DIM_W + 1)'(column_ff) + (DIM_W + 1)'(1);
   assign row_next    = (DIM_W + 1)'(row_ff) + (DIM_W + 1)'(1);
   assign row_end     = column_next >= (DIM_W + 1)'(width_eff);
   assign last_row    = row_next >= (DIM_W + 1)'(height_eff);

   assign cmd.pixel      = req_pixel_rgb565;
   assign cmd.header     = (column_ff == '0) && (row_ff == '0);
   assign cmd.frame_done = row_end && last_row;
   assign cmd.pad_count  = row_end ? width_eff[1:0] : 2'd0;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (cmd_push) begin
         if (row_end) begin
            column_in = '0;
            row_in    = last_row ? '0 : CNT_W'(row_next);
         end else begin
            column_in = CNT_W'(column_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rbf_back.sv =====
// ----------------------------------------------------------------------------
// Formatter back end
// Walks the header, pixel and padding bytes of each queued pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  rbf_pkg::cmd_type       cmd,
   input  rbf_pkg::geom_type      geom,
   output logic                   out_push,
   input  wire logic              out_full,
   output rbf_pkg::out_type       out_item
);

   rbf_pkg::cmd_type                  cur_ff, cur_in;
   logic                              busy_ff, busy_in;
   logic [rbf_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [rbf_pkg::HDR_BYTES-1:0][7:0] hdr;
   logic [rbf_pkg::IDX_W-1:0]         last_idx;
   logic                              is_last;
   logic                              emit;
   logic                              load;
   logic [4:0]                        blue;
   logic [5:0]                        green;
   logic [4:0]                        red;
   logic [7:0]                        byte_val;

   always_comb begin
      hdr        = '0;
      hdr[0]     = rbf_pkg::MAGIC_B;
      hdr[1]     = rbf_pkg::MAGIC_M;
      hdr[5:2]   = geom.file_size;
      hdr[13:10] = rbf_pkg::DATA_OFFSET;
      hdr[17:14] = rbf_pkg::INFO_BYTES;
      hdr[21:18] = geom.width;
      hdr[25:22] = geom.height;
      hdr[27:26] = rbf_pkg::PLANES;
      hdr[29:28] = rbf_pkg::BITS_PER_PIXEL;
      hdr[37:34] = geom.data_size;
      hdr[41:38] = rbf_pkg::PELS_PER_METRE;
      hdr[45:42] = rbf_pkg::PELS_PER_METRE;
   end

   assign blue  = cur_ff.pixel[4:0];
   assign green = cur_ff.pixel[10:5];
   assign red   = cur_ff.pixel[15:11];

   always_comb begin
      priority if (idx_ff < rbf_pkg::IDX_PIX_B) begin
         byte_val = hdr[idx_ff];
      end else if (idx_ff == rbf_pkg::IDX_PIX_B) begin
         byte_val = {blue, blue[4:2]};
      end else if (idx_ff == rbf_pkg::IDX_PIX_G) begin
         byte_val = {green, green[5:4]};
      end else if (idx_ff == rbf_pkg::IDX_PIX_R) begin
         byte_val = {red, red[4:2]};
      end else begin
         byte_val = 8'h00;
      end
   end

   assign last_idx = rbf_pkg::IDX_PIX_R + rbf_pkg::IDX_W'(cur_ff.pad_count);
   assign is_last  = (idx_ff == last_idx);
   assign emit     = busy_ff && !out_full;
   assign load     = !cmd_empty && (!busy_ff || (emit && is_last));
   assign cmd_pop  = load;
   assign out_push = emit;

   assign out_item.file_byte = byte_val;
   assign out_item.run_last  = is_last;
   assign out_item.frame_end = is_last && cur_ff.frame_done;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         cur_in  = cmd;
         busy_in = 1'b1;
         idx_in  = cmd.header ? rbf_pkg::IDX_HDR_FIRST : rbf_pkg::IDX_PIX_B;
      end else if (emit) begin
         busy_in = !is_last;
         idx_in  = idx_ff + rbf_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

// ===== rtl/rgb565_to_bmp24_stream_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// RGB565 to BMP24 stream formatter
// Turns a stream of RGB565 pixels in file order into the bytes of a 24-bit
// BMP file, with the 54-byte header before each frame and row padding.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Handshake
//   -------   --------------------------   -----------------------------
//   input     req_pixel_rgb565             req_push high, req_full low
//   result    rsp_file_byte, rsp_run_last, rsp_pop high, rsp_empty low
//             rsp_frame_end
//   config    csr_index, csr_data          csr_valid high, csr_ready high
//
// One result byte leaves per cycle while the output queue has room; a pixel
// gives 3 bytes, 3 to 6 at the end of a row with padding, and 57 to 60 when
// it opens a frame with the header, as set by the back end's byte sequencer.
// A two-entry queue sits between front and back and another at the output.
// Reset is synchronous; after it the block is ready at once.
// Stalls on either side hold all data until the handshake completes.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_to_bmp24_stream_formatter_unit #(
   parameter int MAX_DIMENSION = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [rbf_pkg::PIXEL_W-1:0]     req_pixel_rgb565,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic      [7:0]                      rsp_file_byte,
   output logic                                 rsp_run_last,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rbf_pkg::CFG_W-1:0]       csr_data
);

   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

   logic [DIM_W-1:0]  width_eff;
   logic [DIM_W-1:0]  height_eff;
   rbf_pkg::geom_type geom;
   rbf_pkg::cmd_type  front_cmd;
   rbf_pkg::cmd_type  back_cmd;
   logic              cmd_push;
   logic              cmd_full;
   logic              cmd_pop;
   logic              cmd_empty;
   rbf_pkg::out_type  back_out;
   rbf_pkg::out_type  rsp_item;
   logic              out_push;
   logic              out_full;

   rbf_csr #(
      .MAX_DIMENSION(MAX_DIMENSION),
      .DIM_W        (DIM_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .width_eff (width_eff),
      .height_eff(height_eff),
      .geom      (geom)
   );

   rbf_front #(
      .MAX_DIMENSION(MAX_DIMENSION),
      .DIM_W        (DIM_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel_rgb565(req_pixel_rgb565),
      .width_eff       (width_eff),
      .height_eff      (height_eff),
      .cmd_push        (cmd_push),
      .cmd_full        (cmd_full),
      .cmd             (front_cmd)
   );

   rbf_fifo #(
      .WIDTH($bits(rbf_pkg::cmd_type)),
      .DEPTH(2)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .full     (cmd_full),
      .push_data(front_cmd),
      .pop      (cmd_pop),
      .empty    (cmd_empty),
      .pop_data (back_cmd)
   );

   rbf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .cmd      (back_cmd),
      .geom     (geom),
      .out_push (out_push),
      .out_full (out_full),
      .out_item (back_out)
   );

   rbf_fifo #(
      .WIDTH($bits(rbf_pkg::out_type)),
      .DEPTH(2)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .full     (out_full),
      .push_data(back_out),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .pop_data (rsp_item)
   );

   assign rsp_file_byte = rsp_item.file_byte;
   assign rsp_run_last  = rsp_item.run_last;
   assign rsp_frame_end = rsp_item.frame_end;

endmodule

`default_nettype wire

// ===== rtl/rbf_checker.sv =====
// ----------------------------------------------------------------------------
// Formatter port checker
// Watches the formatter's ports and flags broken stream behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_file_byte,
   input wire logic       rsp_run_last,
   input wire logic       rsp_frame_end
);

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("Queues are not empty after reset.");

   a_frame_end_is_run_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_run_last)
      else $error("End of file byte is not the last byte of its pixel.");

   a_header_follows_frame : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_frame_end)
      |=> (rsp_empty || (rsp_file_byte == rbf_pkg::MAGIC_B)))
      else $error("Word after end of file does not start a new header.");

   a_stalled_word_holds : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop)
      |=> (!rsp_empty && $stable(rsp_file_byte) && $stable(rsp_run_last)))
      else $error("Stalled result word changed.");

endmodule

bind rgb565_to_bmp24_stream_formatter_unit rbf_checker u_rbf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_file_byte(rsp_file_byte),
   .rsp_run_last (rsp_run_last),
   .rsp_frame_end(rsp_frame_end)
);

`default_nettype wire
